// File: rtl/afm_pkg.sv
package afm_pkg;

    localparam int DataWidth = 16;

    // ALU opcodes; every other code holds the kept result and flags
    localparam logic [3:0] FUNC_HOLD = 4'd0;
    localparam logic [3:0] FUNC_ADD  = 4'd1;
    localparam logic [3:0] FUNC_SUB  = 4'd2;
    localparam logic [3:0] FUNC_RSUB = 4'd3;
    localparam logic [3:0] FUNC_OR   = 4'd4;
    localparam logic [3:0] FUNC_AND  = 4'd5;
    localparam logic [3:0] FUNC_XOR  = 4'd6;
    localparam logic [3:0] FUNC_SRA  = 4'd7;
    localparam logic [3:0] FUNC_SHL  = 4'd8;

    localparam logic [14:0] MagFullMax    = 15'h7fff;
    localparam logic [10:0] MagReducedMax = 11'h07ff;
    localparam logic [15:0] MostNegFull   = 16'h8000;
    localparam logic [11:0] MostNegRed    = 12'h800;
    localparam logic [14:0] ProductSat    = 15'h7fff;

    typedef struct packed {
        logic [DataWidth-1:0] result;
        logic                 ovf;
        logic                 zero;
        logic                 minus;
    } t_alu_state;

    function automatic logic is_active(input logic [3:0] func);
        return (func >= FUNC_ADD) && (func <= FUNC_SHL);
    endfunction

endpackage

// File: rtl/afm_in_if.sv
interface afm_in_if;
    import afm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [3:0]                  func;
    logic signed [DataWidth-1:0] a_operand;
    logic signed [DataWidth-1:0] b_operand;
    logic signed [DataWidth-1:0] mul_left;
    logic signed [DataWidth-1:0] mul_right;
    logic                        full_precision;

    modport source (
        output valid, func, a_operand, b_operand, mul_left, mul_right, full_precision,
        input  ready
    );
    modport sink (
        input  valid, func, a_operand, b_operand, mul_left, mul_right, full_precision,
        output ready
    );
endinterface

// File: rtl/afm_out_if.sv
interface afm_out_if;
    import afm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [DataWidth-1:0] alu_result;
    logic                        overflow_flag;
    logic                        zero_flag;
    logic                        minus_flag;
    logic signed [DataWidth-1:0] product;

    modport source (
        output valid, alu_result, overflow_flag, zero_flag, minus_flag, product,
        input  ready
    );
    modport sink (
        input  valid, alu_result, overflow_flag, zero_flag, minus_flag, product,
        output ready
    );
endinterface

// File: rtl/afm_alu.sv
module afm_alu (
    input  logic [3:0]                    i_func,
    input  logic [afm_pkg::DataWidth-1:0] i_a,
    input  logic [afm_pkg::DataWidth-1:0] i_b,
    input  afm_pkg::t_alu_state           i_held,
    output afm_pkg::t_alu_state           o_next
);
    import afm_pkg::*;

    logic [DataWidth:0]   w_sum;
    logic [DataWidth-1:0] w_res;
    logic                 w_ovf;

    always_comb begin
        w_sum = '0;
        w_res = '0;
        w_ovf = 1'b0;
        unique case (i_func)
            FUNC_ADD: begin
                w_sum = {i_a[DataWidth-1], i_a} + {i_b[DataWidth-1], i_b};
                w_res = w_sum[DataWidth-1:0];
                w_ovf = w_sum[DataWidth] ^ w_sum[DataWidth-1];
            end
            FUNC_SUB: begin
                w_sum = {i_a[DataWidth-1], i_a} - {i_b[DataWidth-1], i_b};
                w_res = w_sum[DataWidth-1:0];
                w_ovf = w_sum[DataWidth] ^ w_sum[DataWidth-1];
            end
            FUNC_RSUB: begin
                w_sum = {i_b[DataWidth-1], i_b} - {i_a[DataWidth-1], i_a};
                w_res = w_sum[DataWidth-1:0];
                w_ovf = w_sum[DataWidth] ^ w_sum[DataWidth-1];
            end
            FUNC_OR:  w_res = i_a | i_b;
            FUNC_AND: w_res = i_a & i_b;
            FUNC_XOR: w_res = i_a ^ i_b;
            FUNC_SRA: begin
                w_res = {i_a[DataWidth-1], i_a[DataWidth-1:1]};
                w_ovf = i_a[0];
            end
            FUNC_SHL: begin
                w_res = {i_a[DataWidth-2:0], 1'b0};
                w_ovf = i_a[DataWidth-1];
            end
            default: begin
                w_res = '0;
                w_ovf = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (is_active(i_func)) begin
            o_next.result = w_res;
            o_next.ovf    = w_ovf;
            o_next.zero   = (w_res == '0);
            o_next.minus  = w_res[DataWidth-1];
        end else begin
            o_next = i_held;
        end
    end
endmodule

// File: rtl/afm_mul.sv
module afm_mul (
    input  logic [afm_pkg::DataWidth-1:0] i_left,
    input  logic [afm_pkg::DataWidth-1:0] i_right,
    input  logic                          i_full,
    output logic [afm_pkg::DataWidth-1:0] o_product
);
    import afm_pkg::*;

    logic [11:0]          w_red_l, w_red_r;
    logic [11:0]          w_abs_red_l, w_abs_red_r;
    logic [15:0]          w_abs_l, w_abs_r;
    logic [14:0]          w_mag_l, w_mag_r;
    logic [29:0]          w_prod;
    logic [14:0]          w_mag;
    logic                 w_sat;
    logic                 w_neg;
    logic                 w_pos_l, w_pos_r;
    logic [DataWidth-1:0] w_mag16;

    // reduced mode: drop four low bits with an arithmetic shift
    assign w_red_l = i_left[15:4];
    assign w_red_r = i_right[15:4];

    assign w_abs_l     = i_left[15]  ? (~i_left + 16'd1)   : i_left;
    assign w_abs_r     = i_right[15] ? (~i_right + 16'd1)  : i_right;
    assign w_abs_red_l = w_red_l[11] ? (~w_red_l + 12'd1)  : w_red_l;
    assign w_abs_red_r = w_red_r[11] ? (~w_red_r + 12'd1)  : w_red_r;

    always_comb begin
        if (i_full) begin
            w_mag_l = (i_left  == MostNegFull) ? MagFullMax : w_abs_l[14:0];
            w_mag_r = (i_right == MostNegFull) ? MagFullMax : w_abs_r[14:0];
            w_sat   = (i_left == MostNegFull) && (i_right == MostNegFull);
        end else begin
            w_mag_l = {4'd0, (w_red_l == MostNegRed) ? MagReducedMax : w_abs_red_l[10:0]};
            w_mag_r = {4'd0, (w_red_r == MostNegRed) ? MagReducedMax : w_abs_red_r[10:0]};
            w_sat   = (w_red_l == MostNegRed) && (w_red_r == MostNegRed);
        end
    end

    assign w_prod = w_mag_l * w_mag_r;

    always_comb begin
        if (w_sat) begin
            w_mag = ProductSat;
        end else if (i_full) begin
            w_mag = w_prod[29:15];
        end else begin
            w_mag = w_prod[21:7];
        end
    end

    // sign from the original operands, zero counts as neither sign
    assign w_pos_l = !i_left[15]  && (i_left  != '0);
    assign w_pos_r = !i_right[15] && (i_right != '0);
    assign w_neg   = (w_pos_l && i_right[15]) || (i_left[15] && w_pos_r);

    assign w_mag16   = {1'b0, w_mag};
    assign o_product = w_neg ? (~w_mag16 + 16'd1) : w_mag16;
endmodule

// File: rtl/alu_and_fraction_multiplier_core.sv
// Execute unit: 16-bit ALU with overflow, zero and minus flags, plus a Q15
// sign-magnitude fraction multiplier.
//
// i_in  carries one microinstruction per beat: opcode, two ALU operands,
//       two multiplier operands and the precision mode.
// o_out carries one result per input beat, in order: ALU result, the three
//       flags and the product. Hold opcodes repeat the kept result and flags.
//
// A beat lands in the input register, the ALU and the 15x15 magnitude
// multiplier work on it combinationally and the result register takes it.
// Throughput is one beat per cycle while the receiver is ready, set by the
// single pass through the multiplier between those two registers.
//
// When the receiver stalls, the result register holds and the input
// register still takes one more beat; i_in.ready drops only when both
// are full. Reset clears both valid bits and the kept result and flags.
module alu_and_fraction_multiplier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    afm_in_if.sink     i_in,
    afm_out_if.source  o_out
);
    import afm_pkg::*;

    logic                 r_in_valid;
    logic [3:0]           r_func;
    logic [DataWidth-1:0] r_a, r_b, r_ml, r_mr;
    logic                 r_full;

    logic                 r_out_valid;
    t_alu_state           r_held;
    t_alu_state           n_held;
    logic [DataWidth-1:0] r_product;
    logic [DataWidth-1:0] n_product;

    logic                 w_adv;
    logic                 w_load;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_load     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    afm_alu u_alu (
        .i_func (r_func),
        .i_a    (r_a),
        .i_b    (r_b),
        .i_held (r_held),
        .o_next (n_held)
    );

    afm_mul u_mul (
        .i_left    (r_ml),
        .i_right   (r_mr),
        .i_full    (r_full),
        .o_product (n_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_func <= i_in.func;
            r_a    <= i_in.a_operand;
            r_b    <= i_in.b_operand;
            r_ml   <= i_in.mul_left;
            r_mr   <= i_in.mul_right;
            r_full <= i_in.full_precision;
        end
    end

    // the kept state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_held      <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_load) begin
                r_held <= n_held;
            end
        end
        if (w_load) begin
            r_product <= n_product;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.alu_result    = r_held.result;
    assign o_out.overflow_flag = r_held.ovf;
    assign o_out.zero_flag     = r_held.zero;
    assign o_out.minus_flag    = r_held.minus;
    assign o_out.product       = r_product;

    a_hold_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && !is_active(r_func) |=> $stable(r_held))
        else $error("hold opcode changed the kept result or flags");

    a_zero_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && is_active(r_func) |=> r_held.zero == (r_held.result == '0))
        else $error("zero flag disagrees with result");

    a_minus_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && is_active(r_func) |=> r_held.minus == r_held.result[DataWidth-1])
        else $error("minus flag disagrees with result");

    a_load_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_out_valid)
        else $error("advanced beat did not reach the result register");

    a_empty_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");
endmodule

// File: test/alu_and_fraction_multiplier_core_tb.sv
`timescale 1ns / 1ps

module alu_and_fraction_multiplier_core_tb;
    import afm_pkg::*;

    localparam int ClkHalf       = 6;
    localparam int ResetCycles   = 8;
    localparam int RandomBeats   = 400;
    localparam int LongStall     = 48;
    localparam int DrainCycles   = 4;
    localparam int WatchdogLimit = 600;
    localparam int MaxReports    = 10;

    // codes outside 1..8 that also hold the kept result and flags
    localparam logic [3:0] FUNC_SPARE_FIRST = 4'd9;
    localparam logic [3:0] FUNC_SPARE_LAST  = 4'd15;

    typedef struct packed {
        logic [3:0]           func;
        logic [DataWidth-1:0] alu_a;
        logic [DataWidth-1:0] alu_b;
        logic [DataWidth-1:0] mul_l;
        logic [DataWidth-1:0] mul_r;
        logic                 full_prec;
    } t_exec_beat;

    typedef struct packed {
        logic [DataWidth-1:0] result;
        logic                 ovf;
        logic                 zero;
        logic                 minus;
        logic [DataWidth-1:0] product;
    } t_exec_result;

    typedef struct packed {
        t_exec_beat   beat;
        logic         typed;
        t_exec_result want;
    } t_dir_row;

    localparam int NumDirected = 22;

    // typed rows carry their result; the rest go through the predictor
    localparam t_dir_row DirectedRows [NumDirected] = '{
        //   func       A         B         mul L     mul R    full   typed  result   V  Z  N  product
        '{'{FUNC_HOLD, 16'h1234, 16'h4321, 16'h0000, 16'h0000, 1'b1}, 1'b1,
          '{16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000}},
        '{'{FUNC_ADD,  16'h7fff, 16'h0001, 16'h8000, 16'h8000, 1'b1}, 1'b1,
          '{16'h8000, 1'b1, 1'b0, 1'b1, 16'h7fff}},
        '{'{FUNC_ADD,  16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b1}, 1'b1,
          '{16'h0000, 1'b1, 1'b1, 1'b0, 16'h7ffe}},
        '{'{FUNC_SUB,  16'h8000, 16'h0001, 16'h8000, 16'h7fff, 1'b1}, 1'b1,
          '{16'h7fff, 1'b1, 1'b0, 1'b0, 16'h8002}},
        '{'{FUNC_RSUB, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 1'b1}, 1'b1,
          '{16'h8000, 1'b1, 1'b0, 1'b1, 16'h0000}},
        '{'{FUNC_OR,   16'hff00, 16'h00ff, 16'hffff, 16'h4000, 1'b1}, 1'b1,
          '{16'hffff, 1'b0, 1'b0, 1'b1, 16'h0000}},
        '{'{FUNC_AND,  16'haaaa, 16'h5555, 16'h4000, 16'h4000, 1'b1}, 1'b1,
          '{16'h0000, 1'b0, 1'b1, 1'b0, 16'h2000}},
        '{'{FUNC_XOR,  16'hffff, 16'h8000, 16'h4000, 16'hc000, 1'b1}, 1'b1,
          '{16'h7fff, 1'b0, 1'b0, 1'b0, 16'he000}},
        '{'{FUNC_SRA,  16'h8001, 16'h0000, 16'h8000, 16'h8000, 1'b0}, 1'b1,
          '{16'hc000, 1'b1, 1'b0, 1'b1, 16'h7fff}},
        '{'{FUNC_SRA,  16'hffff, 16'h0000, 16'hfff1, 16'h7fff, 1'b0}, 1'b1,
          '{16'hffff, 1'b1, 1'b0, 1'b1, 16'hfff1}},
        '{'{FUNC_SHL,  16'h8000, 16'h0000, 16'h7fff, 16'h7fff, 1'b0}, 1'b1,
          '{16'h0000, 1'b1, 1'b1, 1'b0, 16'h7fe0}},
        '{'{FUNC_SHL,  16'h4000, 16'h0000, 16'h8000, 16'h7fff, 1'b0}, 1'b1,
          '{16'h8000, 1'b0, 1'b0, 1'b1, 16'h8020}},
        '{'{FUNC_HOLD, 16'h1111, 16'h2222, 16'h000f, 16'h7fff, 1'b0}, 1'b0, '0},
        '{'{FUNC_SPARE_FIRST, 16'hffff, 16'hffff, 16'hfff0, 16'hfff8, 1'b0}, 1'b0, '0},
        '{'{FUNC_SPARE_LAST,  16'h0000, 16'h0000, 16'h8000, 16'h0001, 1'b1}, 1'b0, '0},
        '{'{FUNC_ADD,  16'h7fff, 16'h8000, 16'h8000, 16'hffff, 1'b1}, 1'b0, '0},
        '{'{FUNC_SUB,  16'h0000, 16'h8000, 16'h7fff, 16'h8000, 1'b0}, 1'b0, '0},
        '{'{FUNC_RSUB, 16'h7fff, 16'hffff, 16'hffff, 16'hffff, 1'b0}, 1'b0, '0},
        '{'{FUNC_SRA,  16'h7fff, 16'h0000, 16'h0001, 16'hffff, 1'b1}, 1'b0, '0},
        '{'{FUNC_SHL,  16'hffff, 16'h0000, 16'h8000, 16'h0000, 1'b0}, 1'b0, '0},
        '{'{FUNC_OR,   16'h0000, 16'h0000, 16'h1234, 16'hedcb, 1'b1}, 1'b0, '0},
        '{'{FUNC_XOR,  16'h5555, 16'h5555, 16'h8000, 16'h8000, 1'b1}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    afm_in_if  in_if ();
    afm_out_if out_if ();

    alu_and_fraction_multiplier_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(ClkHalf) i_clk = ~i_clk;

    t_alu_state   kept_state = '0;
    t_exec_result awaited_results [$];
    int           error_count     = 0;
    int           results_checked = 0;
    int           beats_accepted  = 0;
    int           stall_requests  = 0;

    function automatic t_exec_result predict_execute(input t_exec_beat beat);
        logic [16:0] sa, sb, wide;
        logic [15:0] alu_val;
        logic        alu_ovf;
        logic        active;
        logic [11:0] red_l, red_r;
        logic [14:0] mag_l, mag_r, mag;
        logic [29:0] mag_prod;
        logic        pos_l, pos_r;
        t_exec_result res;

        active  = 1'b1;
        alu_ovf = 1'b0;
        alu_val = '0;
        sa = {beat.alu_a[15], beat.alu_a};
        sb = {beat.alu_b[15], beat.alu_b};
        case (beat.func)
            FUNC_ADD, FUNC_SUB, FUNC_RSUB: begin
                if (beat.func == FUNC_ADD) wide = sa + sb;
                else if (beat.func == FUNC_SUB) wide = sa - sb;
                else wide = sb - sa;
                alu_val = wide[15:0];
                // 17-bit result no longer a sign extension of its low half
                alu_ovf = wide[16] ^ wide[15];
            end
            FUNC_OR:  alu_val = beat.alu_a | beat.alu_b;
            FUNC_AND: alu_val = beat.alu_a & beat.alu_b;
            FUNC_XOR: alu_val = beat.alu_a ^ beat.alu_b;
            FUNC_SRA: begin
                alu_val = {beat.alu_a[15], beat.alu_a[15:1]};
                alu_ovf = beat.alu_a[0];
            end
            FUNC_SHL: begin
                alu_val = {beat.alu_a[14:0], 1'b0};
                alu_ovf = beat.alu_a[15];
            end
            default: active = 1'b0;
        endcase
        if (active) begin
            kept_state.result = alu_val;
            kept_state.ovf    = alu_ovf;
            kept_state.zero   = (alu_val == '0);
            kept_state.minus  = alu_val[15];
        end

        if (beat.full_prec) begin
            if (beat.mul_l == MostNegFull && beat.mul_r == MostNegFull) begin
                mag = ProductSat;
            end else begin
                mag_l = (beat.mul_l == MostNegFull) ? MagFullMax :
                        beat.mul_l[15] ? 15'(~beat.mul_l + 16'd1) : beat.mul_l[14:0];
                mag_r = (beat.mul_r == MostNegFull) ? MagFullMax :
                        beat.mul_r[15] ? 15'(~beat.mul_r + 16'd1) : beat.mul_r[14:0];
                mag_prod = mag_l * mag_r;
                mag = 15'(mag_prod >> 15);
            end
        end else begin
            // dropping four bits is an arithmetic shift, so -16..-1 become -1
            red_l = beat.mul_l[15:4];
            red_r = beat.mul_r[15:4];
            if (red_l == MostNegRed && red_r == MostNegRed) begin
                mag = ProductSat;
            end else begin
                mag_l = (red_l == MostNegRed) ? 15'(MagReducedMax) :
                        red_l[11] ? 15'(12'(~red_l + 12'd1)) : 15'(red_l);
                mag_r = (red_r == MostNegRed) ? 15'(MagReducedMax) :
                        red_r[11] ? 15'(12'(~red_r + 12'd1)) : 15'(red_r);
                mag_prod = mag_l * mag_r;
                mag = 15'(mag_prod >> 7);
            end
        end
        // sign comes from the original operands; zero counts as neither
        pos_l = !beat.mul_l[15] && (beat.mul_l != '0);
        pos_r = !beat.mul_r[15] && (beat.mul_r != '0);

        res.result  = kept_state.result;
        res.ovf     = kept_state.ovf;
        res.zero    = kept_state.zero;
        res.minus   = kept_state.minus;
        res.product = ((pos_l && beat.mul_r[15]) || (beat.mul_l[15] && pos_r)) ?
                      16'(-{1'b0, mag}) : {1'b0, mag};
        return res;
    endfunction

    function automatic logic [15:0] rand_word();
        logic [15:0] corners [8] = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001,
                                     16'hffff, 16'hfff1, 16'h000f, 16'hfff0};
        if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 7)];
        return 16'($urandom);
    endfunction

    task automatic send_beat(input t_exec_beat beat, input logic typed,
                             input t_exec_result want);
        t_exec_result predicted;
        in_if.valid          <= 1'b1;
        in_if.func           <= beat.func;
        in_if.a_operand      <= beat.alu_a;
        in_if.b_operand      <= beat.alu_b;
        in_if.mul_left       <= beat.mul_l;
        in_if.mul_right      <= beat.mul_r;
        in_if.full_precision <= beat.full_prec;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = predict_execute(beat);
        awaited_results.push_back(typed ? want : predicted);
        beats_accepted++;
    endtask

    // receiver: 16-bit ready pattern redrawn each lap, long hold-off on request
    logic [15:0] ready_pattern;
    logic [3:0]  pattern_pos;
    int          stall_left;
    int          stalls_served;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready  <= 1'b0;
            ready_pattern <= 16'hffff;
            pattern_pos   <= '0;
            stall_left    <= 0;
            stalls_served <= 0;
        end else if (stall_left != 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stalls_served != stall_requests) begin
            out_if.ready  <= 1'b0;
            stall_left    <= LongStall;
            stalls_served <= stalls_served + 1;
        end else begin
            out_if.ready <= ready_pattern[pattern_pos];
            pattern_pos  <= pattern_pos + 4'd1;
            if (pattern_pos == 4'hf) begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern <= 16'hffff;
                    1:       ready_pattern <= 16'($urandom);
                    2:       ready_pattern <= 16'($urandom | $urandom);
                    default: ready_pattern <= 16'($urandom & $urandom);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_exec_result got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.alu_result, out_if.overflow_flag, out_if.zero_flag,
                    out_if.minus_flag, out_if.product};
            if (awaited_results.size() == 0) begin
                error_count++;
                if (error_count <= MaxReports)
                    $display("%0t: unexpected result beat res=%h prod=%h",
                             $realtime, got.result, got.product);
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (got.result !== want.result || got.ovf !== want.ovf ||
                    got.zero !== want.zero || got.minus !== want.minus ||
                    got.product !== want.product) begin
                    error_count++;
                    if (error_count <= MaxReports) begin
                        $display("%0t: mismatch exp res=%h v=%b z=%b n=%b prod=%h",
                                 $realtime, want.result, want.ovf, want.zero,
                                 want.minus, want.product);
                        $display("%0t:          got res=%h v=%b z=%b n=%b prod=%h",
                                 $realtime, got.result, got.ovf, got.zero,
                                 got.minus, got.product);
                    end
                end
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WatchdogLimit) begin
            $display("Watchdog: no beat moved for %0d cycles", WatchdogLimit);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_exec_beat beat;
        int         burst_left;
        int         gap;
        int         spare_pick;

        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.func           = FUNC_HOLD;
        in_if.a_operand      = '0;
        in_if.b_operand      = '0;
        in_if.mul_left       = '0;
        in_if.mul_right      = '0;
        in_if.full_precision = 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DirectedRows[i])
            send_beat(DirectedRows[i].beat, DirectedRows[i].typed, DirectedRows[i].want);

        burst_left = 0;
        for (int n = 0; n < RandomBeats; n++) begin
            if (n == RandomBeats / 4) begin
                // output side goes quiet while beats keep coming back to back
                stall_requests <= stall_requests + 1;
                burst_left = 40;
            end else if (n == RandomBeats * 5 / 8) begin
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (awaited_results.size() != 0);
            end

            if ($urandom_range(0, 9) == 0) begin
                spare_pick = $urandom_range(0, 7);
                beat.func = (spare_pick == 0) ? FUNC_HOLD :
                            4'(FUNC_SPARE_FIRST + spare_pick - 1);
            end else begin
                beat.func = 4'($urandom_range(FUNC_ADD, FUNC_SHL));
            end
            beat.alu_a     = rand_word();
            beat.alu_b     = rand_word();
            beat.mul_l     = rand_word();
            beat.mul_r     = rand_word();
            beat.full_prec = 1'($urandom);
            send_beat(beat, 1'b0, '0);

            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    in_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Covered %0d beats (%0d directed): all opcodes and spare codes, both",
                 beats_accepted, NumDirected);
        $display("precision modes, %0d results checked, %0d long output stall(s), %0d errors",
                 results_checked, stall_requests, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/afm_pkg.sv
rtl/afm_in_if.sv
rtl/afm_out_if.sv
rtl/afm_alu.sv
rtl/afm_mul.sv
rtl/alu_and_fraction_multiplier_core.sv
test/alu_and_fraction_multiplier_core_tb.sv
